>>> sv/ramr_pkg.sv
package ramr_pkg;

    localparam int FIELD_BITS = 16;
    localparam int NUM_BITS   = 2 * FIELD_BITS + 1;
    localparam int DEN_BITS   = 2 * FIELD_BITS;
    localparam int CNT_BITS   = $clog2(NUM_BITS + 1);

    typedef enum logic [1:0] {
        REQ_ADD = 2'd0,
        REQ_MUL = 2'd1,
        REQ_CMP = 2'd2,
        REQ_NOP = 2'd3
    } t_req;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [FIELD_BITS-1:0] a_num;
        logic [FIELD_BITS-1:0] a_den;
        logic [FIELD_BITS-1:0] b_num;
        logic [FIELD_BITS-1:0] b_den;
    } t_in;

    typedef struct packed {
        logic [NUM_BITS-1:0] res_num;
        logic [DEN_BITS-1:0] res_den;
        logic                is_equal;
    } t_out;

    // Request from the sequencer to the shared divider.
    typedef struct packed {
        logic                start;
        logic [NUM_BITS-1:0] dividend;
        logic [NUM_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [NUM_BITS-1:0] quot;
        logic [NUM_BITS-1:0] rem;
    } t_div_rsp;

endpackage

>>> sv/ramr_div.sv
// Restoring divider, one quotient bit per cycle.
module ramr_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ramr_pkg::t_div_req i_req,
    output ramr_pkg::t_div_rsp o_rsp
);

    logic [ramr_pkg::NUM_BITS-1:0] r_quot, n_quot;
    logic [ramr_pkg::NUM_BITS-1:0] r_rem, n_rem;
    logic [ramr_pkg::NUM_BITS-1:0] r_dvs, n_dvs;
    logic [ramr_pkg::CNT_BITS-1:0] r_cnt, n_cnt;
    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [ramr_pkg::NUM_BITS:0]   w_trial;

    // One shift and trial subtract per cycle.
    always_comb begin
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        w_trial = {r_rem, r_quot[ramr_pkg::NUM_BITS-1]} - {1'b0, r_dvs};
        if (i_req.start) begin
            n_quot = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
            n_cnt  = ramr_pkg::CNT_BITS'(ramr_pkg::NUM_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial[ramr_pkg::NUM_BITS]) begin
                n_rem  = {r_rem[ramr_pkg::NUM_BITS-2:0], r_quot[ramr_pkg::NUM_BITS-1]};
                n_quot = {r_quot[ramr_pkg::NUM_BITS-2:0], 1'b0};
            end else begin
                n_rem  = w_trial[ramr_pkg::NUM_BITS-1:0];
                n_quot = {r_quot[ramr_pkg::NUM_BITS-2:0], 1'b1};
            end
            n_cnt = r_cnt - ramr_pkg::CNT_BITS'(1);
            if (r_cnt == ramr_pkg::CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without run");
    a_idle_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");
    a_cnt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy && !i_req.start |=> !r_busy) else $error("divider woke alone");
`endif

endmodule

>>> sv/rational_add_mul_reduce_top.sv
// Fraction add/multiply with GCD reduction. A transaction is taken when i_start
// is high and o_busy is low; o_valid marks the result for exactly one cycle and
// cannot be stalled, and o_busy stays high through that cycle. Compare and the
// unused request code go straight to the output state. Add and multiply form
// their products through one shared 16x16 multiplier (three products for add,
// two for multiply) and pass a check state, then run Euclid's algorithm on the
// one shared restoring divider (up to about 47 remainder passes for the widest
// operands), followed by two chained divisions by the GCD for the final
// quotients. A zero numerator or zero denominator skips the reduction.
module rational_add_mul_reduce_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ramr_pkg::t_in i_in,
    output logic          o_busy,
    output logic          o_valid,
    output ramr_pkg::t_out o_out
);

    localparam int NB = ramr_pkg::NUM_BITS;
    localparam int DB = ramr_pkg::DEN_BITS;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_CHK  = 9'b000000100,
        S_GST  = 9'b000001000,
        S_GWT  = 9'b000010000,
        S_QNS  = 9'b000100000,
        S_QNW  = 9'b001000000,
        S_QDW  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state                r_state, n_state;
    ramr_pkg::t_in         r_in, n_in;
    logic [1:0]            r_step, n_step;
    logic [NB-1:0]         r_num, n_num;
    logic [NB-1:0]         r_den, n_den;
    logic [NB-1:0]         r_x, n_x;
    logic [NB-1:0]         r_y, n_y;
    logic                  r_eq, n_eq;
    logic                  r_valid, n_valid;
    logic [DB-1:0]         r_prod;
    logic [ramr_pkg::FIELD_BITS-1:0] w_ma, w_mb;
    ramr_pkg::t_div_req    w_dreq;
    ramr_pkg::t_div_rsp    w_drsp;

    ramr_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    // Shared multiplier operand selection, product registered.
    always_comb begin
        case (r_step)
            2'd0:    begin w_ma = r_in.a_den; w_mb = r_in.b_den; end
            2'd1:    begin
                w_ma = r_in.a_num;
                w_mb = (r_in.req_type == ramr_pkg::REQ_MUL) ? r_in.b_num : r_in.b_den;
            end
            default: begin w_ma = r_in.b_num; w_mb = r_in.a_den; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= DB'(w_ma) * DB'(w_mb);
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_in    = r_in;
        n_step  = r_step;
        n_num   = r_num;
        n_den   = r_den;
        n_x     = r_x;
        n_y     = r_y;
        n_eq    = r_eq;
        n_valid = 1'b0;
        w_dreq  = '0;
        case (r_state)
            S_IDLE: begin
                // The result cycle still counts as busy.
                if (i_start && !r_valid) begin
                    n_in   = i_in;
                    n_step = 2'd0;
                    n_num  = '0;
                    n_den  = '0;
                    n_eq   = 1'b0;
                    if (i_in.req_type == ramr_pkg::REQ_ADD ||
                        i_in.req_type == ramr_pkg::REQ_MUL) begin
                        n_state = S_MUL;
                    end else begin
                        n_eq    = (i_in.req_type == ramr_pkg::REQ_CMP) &&
                                  (i_in.a_num == i_in.b_num) && (i_in.a_den == i_in.b_den);
                        n_state = S_OUT;
                    end
                end
            end
            S_MUL: begin
                // Products land in the cycle after their operands are selected.
                n_step = r_step + 2'd1;
                case (r_step)
                    2'd1: n_den = {1'b0, r_prod};
                    2'd2: n_num = {1'b0, r_prod};
                    2'd3: n_num = r_num + {1'b0, r_prod};
                    default: ;
                endcase
                if (r_step == 2'd2 && r_in.req_type == ramr_pkg::REQ_MUL) begin
                    n_state = S_CHK;
                end else if (r_step == 2'd3) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_num == '0 || r_den == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_x     = r_num;
                    n_y     = r_den;
                    n_state = S_GST;
                end
            end
            S_GST: begin
                // y is never zero here; x mod y on the shared divider.
                w_dreq.start    = 1'b1;
                w_dreq.dividend = r_x;
                w_dreq.divisor  = r_y;
                n_state         = S_GWT;
            end
            S_GWT: begin
                if (w_drsp.done) begin
                    n_x = r_y;
                    n_y = w_drsp.rem;
                    n_state = (w_drsp.rem == '0) ? S_QNS : S_GST;
                end
            end
            S_QNS: begin
                w_dreq.start    = 1'b1;
                w_dreq.dividend = r_num;
                w_dreq.divisor  = r_x;
                n_state         = S_QNW;
            end
            S_QNW: begin
                if (w_drsp.done) begin
                    n_num           = w_drsp.quot;
                    w_dreq.start    = 1'b1;
                    w_dreq.dividend = r_den;
                    w_dreq.divisor  = r_x;
                    n_state         = S_QDW;
                end
            end
            S_QDW: begin
                if (w_drsp.done) begin
                    n_den   = w_drsp.quot;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_step  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_step  <= n_step;
        end
        r_in  <= n_in;
        r_num <= n_num;
        r_den <= n_den;
        r_x   <= n_x;
        r_y   <= n_y;
        r_eq  <= n_eq;
    end

    // Result stays on the ports; o_valid marks its one cycle.
    assign o_busy         = (r_state != S_IDLE) || r_valid;
    assign o_valid        = r_valid;
    assign o_out.res_num  = r_num;
    assign o_out.res_den  = r_den[DB-1:0];
    assign o_out.is_equal = r_eq;

`ifndef SYNTHESIS
    a_valid_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state == S_OUT)) else $error("result without finish");
    a_busy_when_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> o_busy) else $error("ready while result shown");
    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> r_state != S_IDLE) else $error("transaction dropped");
    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_GST |-> r_y != '0) else $error("divide by zero in gcd");
`endif

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_start;
    ramr_pkg::t_in  i_in;
    logic           o_busy;
    logic           o_valid;
    ramr_pkg::t_out o_out;

    ramr_pkg::t_out fraction_q[$];
    int   mismatch_count;
    int   send_index;
    int   idle_left;
    bit   idle_on;

    // One directed row: the request, plus a typed expectation where it is obvious.
    typedef struct {
        ramr_pkg::t_in  req;
        bit             has_exp;
        ramr_pkg::t_out exp;
    } t_row;

    t_row rows[$];

    rational_add_mul_reduce_top u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_in   (i_in),
        .o_busy (o_busy),
        .o_valid(o_valid),
        .o_out  (o_out)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Watchdog for a hung design.
    initial begin
        #(64'd80_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    // Euclid on 64-bit values; numerator and denominator both nonzero.
    function automatic logic [63:0] common_divisor(logic [63:0] x, logic [63:0] y);
        logic [63:0] r;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    // Expected reduced fraction or field comparison for one transaction.
    function automatic ramr_pkg::t_out reduce_fraction(ramr_pkg::t_in req);
        logic [63:0]    num;
        logic [63:0]    den;
        logic [63:0]    g;
        ramr_pkg::t_out res;
        num = 0;
        den = 0;
        res = '0;
        if (req.req_type == ramr_pkg::REQ_ADD || req.req_type == ramr_pkg::REQ_MUL) begin
            den = 64'(req.a_den) * 64'(req.b_den);
            if (req.req_type == ramr_pkg::REQ_ADD) begin
                num = 64'(req.a_num) * 64'(req.b_den) + 64'(req.b_num) * 64'(req.a_den);
            end else begin
                num = 64'(req.a_num) * 64'(req.b_num);
            end
            if (num != 0 && den != 0) begin
                g   = common_divisor(num, den);
                num = num / g;
                den = den / g;
            end
        end else if (req.req_type == ramr_pkg::REQ_CMP) begin
            res.is_equal = (req.a_num == req.b_num) && (req.a_den == req.b_den);
        end
        res.res_num = num[ramr_pkg::NUM_BITS-1:0];
        res.res_den = den[ramr_pkg::DEN_BITS-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Result checker: each strobed result is compared with the oldest expectation.
    always @(posedge i_clk) begin
        ramr_pkg::t_out want;
        if (i_rst_n && o_valid) begin
            if (fraction_q.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_out.res_num), '0);
            end else begin
                want = fraction_q.pop_front();
                if (o_out.res_num !== want.res_num)
                    report_mismatch("res_num", 64'(o_out.res_num), 64'(want.res_num));
                if (o_out.res_den !== want.res_den)
                    report_mismatch("res_den", 64'(o_out.res_den), 64'(want.res_den));
                if (o_out.is_equal !== want.is_equal)
                    report_mismatch("is_equal", 64'(o_out.is_equal), 64'(want.is_equal));
            end
        end
    end

    function automatic ramr_pkg::t_in make_req(ramr_pkg::t_req op, int an, int ad,
                                               int bn, int bd);
        ramr_pkg::t_in r;
        r.req_type = op;
        r.a_num    = ramr_pkg::FIELD_BITS'(an);
        r.a_den    = ramr_pkg::FIELD_BITS'(ad);
        r.b_num    = ramr_pkg::FIELD_BITS'(bn);
        r.b_den    = ramr_pkg::FIELD_BITS'(bd);
        return r;
    endfunction

    task automatic add_row(ramr_pkg::t_req op, int an, int ad, int bn, int bd, bit has_exp,
                           longint en, longint ed, bit eq);
        t_row row;
        row.req              = make_req(op, an, ad, bn, bd);
        row.has_exp          = has_exp;
        row.exp.res_num      = ramr_pkg::NUM_BITS'(en);
        row.exp.res_den      = ramr_pkg::DEN_BITS'(ed);
        row.exp.is_equal     = eq;
        rows.push_back(row);
    endtask

    // Random operand: small or full range equally often, sometimes an extreme.
    function automatic int pick_field(bit is_den);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) return $urandom_range(is_den ? 1 : 0, 40);
        if (sel < 8) return $urandom_range(is_den ? 1 : 0, 16'hffff);
        if (sel == 8) return is_den ? 1 : 0;
        return 16'hffff;
    endfunction

    function automatic ramr_pkg::t_in random_req();
        ramr_pkg::t_in r;
        int            sel;
        sel = $urandom_range(0, 19);
        if (sel < 9) r.req_type = ramr_pkg::REQ_ADD;
        else if (sel < 17) r.req_type = ramr_pkg::REQ_MUL;
        else if (sel < 19) r.req_type = ramr_pkg::REQ_CMP;
        else r.req_type = ramr_pkg::REQ_NOP;
        r.a_num = ramr_pkg::FIELD_BITS'(pick_field(0));
        r.a_den = ramr_pkg::FIELD_BITS'(pick_field(1));
        r.b_num = ramr_pkg::FIELD_BITS'(pick_field(0));
        r.b_den = ramr_pkg::FIELD_BITS'(pick_field(1));
        // Equal fields now and then so that compare also reports a match.
        if (r.req_type == ramr_pkg::REQ_CMP && $urandom_range(0, 1)) begin
            r.b_num = r.a_num;
            r.b_den = r.a_den;
        end
        // Occasionally a zero denominator, outside the normal range.
        if ($urandom_range(0, 49) == 0) r.a_den = '0;
        if ($urandom_range(0, 49) == 0) r.b_den = '0;
        return r;
    endfunction

    // Drive one transaction and hold it until the block accepts it. Busy only
    // changes at rising edges, so it is checked at the falling edge before.
    task automatic send_req(ramr_pkg::t_in req, bit has_exp, ramr_pkg::t_out exp_res);
        @(negedge i_clk);
        i_in    <= req;
        i_start <= 1'b1;
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
        fraction_q.push_back(has_exp ? exp_res : reduce_fraction(req));
        @(negedge i_clk);
        i_start <= 1'b0;
    endtask

    // Random gap between transactions, in bursts.
    task automatic sender_gap(bit allow);
        if (!allow) return;
        if (idle_left == 0) begin
            idle_on   = $urandom_range(0, 2) == 0;
            idle_left = $urandom_range(1, 18);
        end
        if (idle_on) repeat (idle_left) @(negedge i_clk);
        idle_left = idle_on ? 0 : idle_left - 1;
    endtask

    initial begin
        ramr_pkg::t_out none;
        int             wait_cycles;
        none           = '0;
        mismatch_count = 0;
        idle_left      = 0;
        idle_on        = 0;
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_in           = '0;

        // Directed table: extremes, every request, zero numerator and denominator.
        add_row(ramr_pkg::REQ_ADD, 0, 1, 0, 1, 1, 0, 1, 0);
        add_row(ramr_pkg::REQ_ADD, 1, 1, 1, 1, 1, 2, 1, 0);
        add_row(ramr_pkg::REQ_ADD, 1, 2, 1, 2, 1, 1, 1, 0);
        add_row(ramr_pkg::REQ_ADD, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, 2, 1, 0);
        add_row(ramr_pkg::REQ_ADD, 16'hffff, 1, 16'hffff, 1, 1, 33'h1fffe, 1, 0);
        add_row(ramr_pkg::REQ_ADD, 0, 16'hffff, 0, 16'hffff, 1, 0, 32'hfffe0001, 0);
        add_row(ramr_pkg::REQ_ADD, 16'hffff, 16'hfffe, 16'hfffe, 16'hffff, 0, 0, 0, 0);
        add_row(ramr_pkg::REQ_ADD, 3, 0, 5, 7, 1, 21, 0, 0);
        add_row(ramr_pkg::REQ_MUL, 0, 5, 7, 3, 1, 0, 15, 0);
        add_row(ramr_pkg::REQ_MUL, 16'hffff, 1, 16'hffff, 1, 1, 32'hfffe0001, 1, 0);
        add_row(ramr_pkg::REQ_MUL, 1, 16'hffff, 1, 16'hffff, 1, 1, 32'hfffe0001, 0);
        add_row(ramr_pkg::REQ_MUL, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, 1, 1, 0);
        add_row(ramr_pkg::REQ_MUL, 2, 3, 3, 2, 1, 1, 1, 0);
        add_row(ramr_pkg::REQ_MUL, 6, 35, 14, 15, 0, 0, 0, 0);
        add_row(ramr_pkg::REQ_MUL, 4, 3, 5, 0, 1, 20, 0, 0);
        add_row(ramr_pkg::REQ_MUL, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 0, 0, 0, 0);
        add_row(ramr_pkg::REQ_CMP, 1, 2, 1, 2, 1, 0, 0, 1);
        add_row(ramr_pkg::REQ_CMP, 1, 2, 2, 4, 1, 0, 0, 0);
        add_row(ramr_pkg::REQ_CMP, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, 0, 0, 1);
        add_row(ramr_pkg::REQ_CMP, 0, 1, 0, 2, 1, 0, 0, 0);
        add_row(ramr_pkg::REQ_NOP, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, 0, 0, 0);
        add_row(ramr_pkg::REQ_NOP, 0, 1, 0, 1, 1, 0, 0, 0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[k]) begin
            send_req(rows[k].req, rows[k].has_exp, rows[k].exp);
            sender_gap(1);
        end

        // Random part; the last stretch runs with no gaps.
        for (send_index = 0; send_index < 1300; send_index++) begin
            send_req(random_req(), 0, none);
            // Hold off until every outstanding result has come back.
            if (send_index == 400 || send_index == 900)
                while (fraction_q.size() != 0) @(negedge i_clk);
            sender_gap(send_index < 1150);
        end

        // Drain, then a short tail for stray results.
        wait_cycles = 0;
        while (fraction_q.size() != 0 && wait_cycles < 20000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (400) @(negedge i_clk);
        if (mismatch_count == 0 && fraction_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/ramr_pkg.sv
sv/ramr_div.sv
sv/rational_add_mul_reduce_top.sv
verif/testbench.sv
